// ===== rtl/cbcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcr_pkg
// shared types and constants of the circle/box collision resolver
// ----------------------------------------------------------------------------
package cbcr_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_DETECT      = 2'd0;
    localparam t_cmd CMD_STOP_CIRCLE = 2'd1;
    localparam t_cmd CMD_STOP_BOX    = 2'd2;
    localparam t_cmd CMD_PUSH        = 2'd3;

    // per-item control that rides along the sqrt and divide pipes
    typedef struct packed {
        t_cmd cmd;
        logic hit;
        logic men;  // moves enabled: hit, resolve mode, nonzero distance
        logic sx;   // sign of x offset
        logic sy;   // sign of y offset
    } t_ctl;

endpackage

// ===== rtl/cbcr_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcr_isqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module cbcr_isqrt #(
    parameter int RAD_W  = 50,
    parameter int SIDE_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int NS = RAD_W / 2;

    logic              r_v    [NS];
    logic [RAD_W-1:0]  r_rad  [NS];
    logic [NS-1:0]     r_root [NS];
    logic [NS+1:0]     r_rem  [NS];
    logic [SIDE_W-1:0] r_side [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic              p_v;
        logic [RAD_W-1:0]  p_rad;
        logic [NS-1:0]     p_root;
        logic [NS+1:0]     p_rem;
        logic [SIDE_W-1:0] p_side;
        logic [NS+3:0]     rem_sh;
        logic [NS+3:0]     trial;
        logic [NS+3:0]     diff;
        logic              ge;
        logic [NS+1:0]     n_rem;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rad  = i_rad;
            assign p_root = '0;
            assign p_rem  = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_root = r_root[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_side = r_side[k-1];
        end

        assign rem_sh = {p_rem, p_rad[RAD_W-1 -: 2]};
        assign trial  = {2'b00, p_root, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign diff   = rem_sh - trial;
        assign n_rem  = ge ? diff[NS+1:0] : rem_sh[NS+1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= p_rad << 2;
                r_root[k] <= {p_root[NS-2:0], ge};
                r_rem[k]  <= n_rem;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== rtl/cbcr_div2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcr_div2
// pipelined restoring divider, two dividends over one divisor, bit per stage
// ----------------------------------------------------------------------------
module cbcr_div2 #(
    parameter int QW = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2*QW-1:0]     i_num_x,
    input  logic [2*QW-1:0]     i_num_y,
    input  logic [QW:0]         i_div,
    input  cbcr_pkg::t_ctl      i_ctl,
    output logic                o_valid,
    output logic [QW-1:0]       o_q_x,
    output logic [QW-1:0]       o_q_y,
    output cbcr_pkg::t_ctl      o_ctl
);
    import cbcr_pkg::*;

    // quotient is known to fit QW bits, so the upper half starts as remainder
    logic          r_v    [QW];
    logic [QW:0]   r_div  [QW];
    logic [QW:0]   r_rem  [QW][2];
    logic [QW-1:0] r_low  [QW][2];
    t_ctl          r_ctl  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic        p_v;
        logic [QW:0] p_div;
        t_ctl        p_ctl;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_div = i_div;
            assign p_ctl = i_ctl;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_div = r_div[k-1];
            assign p_ctl = r_ctl[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[k] <= p_div;
                r_ctl[k] <= p_ctl;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [QW:0]   p_rem;
            logic [QW-1:0] p_low;
            logic [QW+1:0] t;
            logic [QW+1:0] diff;
            logic          ge;
            logic [QW:0]   n_rem;

            if (k == 0) begin : g_first
                logic [2*QW-1:0] num;
                assign num   = (l == 0) ? i_num_x : i_num_y;
                assign p_rem = {1'b0, num[2*QW-1:QW]};
                assign p_low = num[QW-1:0];
            end else begin : g_next
                assign p_rem = r_rem[k-1][l];
                assign p_low = r_low[k-1][l];
            end

            assign t     = {p_rem, p_low[QW-1]};
            assign ge    = (t >= {1'b0, p_div});
            assign diff  = t - {1'b0, p_div};
            assign n_rem = ge ? diff[QW:0] : t[QW:0];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= n_rem;
                    r_low[k][l] <= {p_low[QW-2:0], ge};
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q_x   = r_low[QW-1][0];
    assign o_q_y   = r_low[QW-1][1];
    assign o_ctl   = r_ctl[QW-1];

endmodule

// ===== rtl/circle_box_collision_resolve_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_box_collision_resolve_top
// circle versus axis-aligned box test with stop/push correction moves
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid/o_ready with one circle and one box per beat plus a
//   mode in i_cmd; output channel: o_valid/i_ready with hit and four moves
//   one result beat per input beat, in order
//   the bit-per-stage square root (COORD_WIDTH+1 stages) and divider
//   (COORD_WIDTH stages) make up most of the pipe
//   throughput: one beat per cycle while the receiver keeps i_ready high
//   the whole pipe advances together; when the result register holds a beat
//   the receiver has not taken, every stage freezes, and the first stage
//   still takes a new beat if it is empty
//   reset clears all valid bits; data registers are not reset
//   internal arithmetic works in half-lsb units so box half extents are exact
// ----------------------------------------------------------------------------
module circle_box_collision_resolve_top #(
    parameter int COORD_WIDTH = cbcr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  cbcr_pkg::t_cmd                i_cmd,
    input  logic signed [COORD_WIDTH-1:0] i_circle_x,
    input  logic signed [COORD_WIDTH-1:0] i_circle_y,
    input  logic        [COORD_WIDTH-2:0] i_circle_radius,
    input  logic signed [COORD_WIDTH-1:0] i_box_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_y,
    input  logic        [COORD_WIDTH-2:0] i_box_width,
    input  logic        [COORD_WIDTH-2:0] i_box_height,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_circle_dx,
    output logic signed [COORD_WIDTH-1:0] o_circle_dy,
    output logic signed [COORD_WIDTH-1:0] o_box_dx,
    output logic signed [COORD_WIDTH-1:0] o_box_dy
);
    import cbcr_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 3;           // clamped offset, half-lsb units
    localparam int CTL_W  = $bits(t_ctl);
    localparam int SIDE_W = CTL_W + 3 * W;   // ctl, r2, ax, ay

    // global advance; the first stage may also fill a bubble during a stall
    logic en;
    logic r_out_v;
    logic r1_v;

    assign en      = ~r_out_v | i_ready;
    assign o_ready = en | ~r1_v;

    // ---------------- stage 1: clamp center to box, offset per axis ----------
    logic signed [DW-1:0] r1_dx, r1_dy;
    logic        [W-1:0]  r1_r2;
    t_cmd                 r1_cmd;

    function automatic logic signed [DW-1:0] axis_delta(
        input logic signed [W-1:0] c,
        input logic signed [W-1:0] bc,
        input logic        [W-2:0] sz
    );
        logic signed [W+1:0] c2, b2, lo, hi, p;
        begin
            c2 = {{1{c[W-1]}}, c, 1'b0};
            b2 = {{1{bc[W-1]}}, bc, 1'b0};
            lo = b2 - $signed({3'b000, sz});
            hi = b2 + $signed({3'b000, sz});
            p  = (c2 < hi) ? c2 : hi;
            p  = (p < lo) ? lo : p;
            axis_delta = DW'(c2) - DW'(p);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (o_ready) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r1_cmd <= i_cmd;
            r1_dx  <= axis_delta(i_circle_x, i_box_x, i_box_width);
            r1_dy  <= axis_delta(i_circle_y, i_box_y, i_box_height);
            r1_r2  <= {i_circle_radius, 1'b0};
        end
    end

    // ---------------- stage 2: magnitudes and range gate ---------------------
    logic            r2_v;
    t_cmd            r2_cmd;
    logic [W-1:0]    r2_ax, r2_ay, r2_r2;
    logic            r2_sx, r2_sy, r2_inr;
    logic [DW-1:0]   ax_full, ay_full;

    assign ax_full = r1_dx[DW-1] ? DW'(-r1_dx) : DW'(r1_dx);
    assign ay_full = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd <= r1_cmd;
            r2_ax  <= ax_full[W-1:0];
            r2_ay  <= ay_full[W-1:0];
            r2_sx  <= r1_dx[DW-1];
            r2_sy  <= r1_dy[DW-1];
            // beyond the radius on either axis is a miss; keeps squares narrow
            r2_inr <= (ax_full <= DW'(r1_r2)) && (ay_full <= DW'(r1_r2));
            r2_r2  <= r1_r2;
        end
    end

    // ---------------- stage 3: squares ---------------------------------------
    logic            r3_v;
    t_cmd            r3_cmd;
    logic [2*W-1:0]  r3_xs, r3_ys, r3_rsq;
    logic [W-1:0]    r3_ax, r3_ay, r3_r2;
    logic            r3_sx, r3_sy, r3_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd <= r2_cmd;
            r3_xs  <= r2_ax * r2_ax;
            r3_ys  <= r2_ay * r2_ay;
            r3_rsq <= r2_r2 * r2_r2;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_r2  <= r2_r2;
            r3_sx  <= r2_sx;
            r3_sy  <= r2_sy;
            r3_inr <= r2_inr;
        end
    end

    // ---------------- stage 4: distance squared and hit ----------------------
    logic            r4_v;
    t_ctl            r4_ctl;
    logic [2*W:0]    r4_dsq;
    logic [W-1:0]    r4_ax, r4_ay, r4_r2;
    logic [2*W:0]    dsq;
    logic            hit;
    t_ctl            n4_ctl;

    assign dsq = {1'b0, r3_xs} + {1'b0, r3_ys};

    always_comb begin
        if (r3_cmd == CMD_DETECT) begin
            hit = r3_inr && (dsq < {1'b0, r3_rsq});
        end else begin
            hit = r3_inr && (dsq <= {1'b0, r3_rsq});
        end
        n4_ctl.cmd = r3_cmd;
        n4_ctl.hit = hit;
        // center on or inside the box: hit without any move
        n4_ctl.men = hit && (r3_cmd != CMD_DETECT) && (dsq != '0);
        n4_ctl.sx  = r3_sx;
        n4_ctl.sy  = r3_sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ctl <= n4_ctl;
            r4_dsq <= dsq;
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_r2  <= r3_r2;
        end
    end

    // ---------------- square root of the distance ----------------------------
    logic              sq_v;
    logic [W:0]        sq_root;
    logic [SIDE_W-1:0] sq_side;

    cbcr_isqrt #(
        .RAD_W  (2 * W + 2),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_rad   ({1'b0, r4_dsq}),
        .i_side  ({r4_ctl, r4_r2, r4_ax, r4_ay}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    t_ctl         sq_ctl;
    logic [W-1:0] sq_r2, sq_ax, sq_ay;

    assign {sq_ctl, sq_r2, sq_ax, sq_ay} = sq_side;

    // ---------------- stage 5: penetration ------------------------------------
    logic         r5_v;
    t_ctl         r5_ctl;
    logic [W-1:0] r5_pen, r5_ax, r5_ay;
    logic [W:0]   r5_s;
    logic [W:0]   pen_full;

    assign pen_full = {1'b0, sq_r2} - sq_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ctl <= sq_ctl;
            r5_pen <= ({1'b0, sq_r2} >= sq_root) ? pen_full[W-1:0] : '0;
            r5_s   <= sq_root;
            r5_ax  <= sq_ax;
            r5_ay  <= sq_ay;
        end
    end

    // ---------------- stage 6: penetration times offset -----------------------
    logic           r6_v;
    t_ctl           r6_ctl;
    logic [2*W-1:0] r6_nx, r6_ny;
    logic [W:0]     r6_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ctl <= r5_ctl;
            r6_nx  <= r5_pen * r5_ax;
            r6_ny  <= r5_pen * r5_ay;
            r6_s   <= r5_s;
        end
    end

    // ---------------- divide by the root --------------------------------------
    // q = floor(n/s); full move (q+1)>>1, half move (q+2)>>2 round as required
    logic         dv_v;
    logic [W-1:0] dv_qx, dv_qy;
    t_ctl         dv_ctl;

    cbcr_div2 #(
        .QW (W)
    ) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num_x (r6_nx),
        .i_num_y (r6_ny),
        .i_div   (r6_s),
        .i_ctl   (r6_ctl),
        .o_valid (dv_v),
        .o_q_x   (dv_qx),
        .o_q_y   (dv_qy),
        .o_ctl   (dv_ctl)
    );

    // ---------------- output register: round, sign, select, saturate ----------
    function automatic logic signed [W-1:0] signed_move(
        input logic [W-1:0] mag,
        input logic         neg
    );
        logic signed [W:0] v;
        begin
            v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (v[W] != v[W-1]) begin
                signed_move = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                signed_move = v[W-1:0];
            end
        end
    endfunction

    logic [W:0]          qx1, qy1, qx2, qy2;
    logic [W-1:0]        fx, fy, hx, hy;
    logic signed [W-1:0] n_cdx, n_cdy, n_bdx, n_bdy;
    t_cmd                r_out_cmd;

    assign qx1 = {1'b0, dv_qx} + (W+1)'(1);
    assign qy1 = {1'b0, dv_qy} + (W+1)'(1);
    assign qx2 = {1'b0, dv_qx} + (W+1)'(2);
    assign qy2 = {1'b0, dv_qy} + (W+1)'(2);
    assign fx  = qx1[W:1];
    assign fy  = qy1[W:1];
    assign hx  = {1'b0, qx2[W:2]};
    assign hy  = {1'b0, qy2[W:2]};

    always_comb begin
        n_cdx = '0;
        n_cdy = '0;
        n_bdx = '0;
        n_bdy = '0;
        if (dv_ctl.men) begin
            unique case (dv_ctl.cmd)
                CMD_STOP_CIRCLE: begin
                    n_cdx = signed_move(fx, dv_ctl.sx);
                    n_cdy = signed_move(fy, dv_ctl.sy);
                end
                CMD_STOP_BOX: begin
                    n_bdx = signed_move(fx, ~dv_ctl.sx);
                    n_bdy = signed_move(fy, ~dv_ctl.sy);
                end
                CMD_PUSH: begin
                    n_cdx = signed_move(hx, dv_ctl.sx);
                    n_cdy = signed_move(hy, dv_ctl.sy);
                    n_bdx = signed_move(hx, ~dv_ctl.sx);
                    n_bdy = signed_move(hy, ~dv_ctl.sy);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_cmd   <= dv_ctl.cmd;
            o_hit       <= dv_ctl.hit;
            o_circle_dx <= n_cdx;
            o_circle_dy <= n_cdy;
            o_box_dx    <= n_bdx;
            o_box_dy    <= n_bdy;
        end
    end

    assign o_valid = r_out_v;

    // ---------------- assertions ----------------------------------------------
    a_miss_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_circle_dx == '0 && o_circle_dy == '0 &&
                                 o_box_dx == '0 && o_box_dy == '0))
        else $error("move reported without a hit");

    a_detect_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_cmd == CMD_DETECT) |->
            (o_circle_dx == '0 && o_circle_dy == '0 &&
             o_box_dx == '0 && o_box_dy == '0))
        else $error("move reported in detect mode");

    a_stop_circle_box_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_cmd == CMD_STOP_CIRCLE) |-> (o_box_dx == '0 && o_box_dy == '0))
        else $error("box moved in circle stop mode");

    a_stall_holds_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r1_v) |=> (r1_v && $stable(r1_dx) && $stable(r1_dy)))
        else $error("first stage changed during a stall");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the circle/box collision resolver: directed corner
// pairs, then random pairs biased toward contact; each result beat is checked in
// order with a typed answer or a behavioral model of hit test and correction moves
// ----------------------------------------------------------------------------
module tb;
    import cbcr_pkg::*;

    localparam int  CW        = 24;
    localparam int  N_RANDOM  = 1080;
    localparam int  IDLE_MAX  = 3000;
    localparam longint SMAX   = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint SMIN   = -SMAX - 1;

    typedef struct {
        t_cmd                 cmd;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic        [CW-2:0] r;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic        [CW-2:0] w;
        logic        [CW-2:0] h;
    } t_pair;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] cdx;
        logic signed [CW-1:0] cdy;
        logic signed [CW-1:0] bdx;
        logic signed [CW-1:0] bdy;
    } t_res;

    // directed row: a pair and, where obvious, the typed-in answer
    typedef struct {
        t_pair pair;
        bit    typed;
        t_res  res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    t_cmd                 i_cmd = CMD_DETECT;
    logic signed [CW-1:0] i_circle_x = '0;
    logic signed [CW-1:0] i_circle_y = '0;
    logic        [CW-2:0] i_circle_radius = '0;
    logic signed [CW-1:0] i_box_x = '0;
    logic signed [CW-1:0] i_box_y = '0;
    logic        [CW-2:0] i_box_width = '0;
    logic        [CW-2:0] i_box_height = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_hit;
    logic signed [CW-1:0] o_circle_dx;
    logic signed [CW-1:0] o_circle_dy;
    logic signed [CW-1:0] o_box_dx;
    logic signed [CW-1:0] o_box_dy;

    t_res pending_res[$];
    int   n_errors   = 0;
    int   n_sent     = 0;
    int   n_results  = 0;
    int   n_hits     = 0;
    int   n_moves    = 0;
    int   idle_count = 0;
    bit   held_off   = 1'b0;

    circle_box_collision_resolve_top #(.COORD_WIDTH(CW)) dut (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // behavioral model, all lengths in half-lsb units
    // ------------------------------------------------------------------------

    // twice the center minus its clamp into the doubled box span
    function automatic longint axis_off(longint c, longint bc, longint size);
        longint c2, lo, hi, p;
        c2 = 2 * c;
        lo = 2 * bc - size;
        hi = 2 * bc + size;
        p  = (c2 < hi) ? c2 : hi;
        if (p < lo) p = lo;
        return c2 - p;
    endfunction

    // rounded pen*|d|/den, ties away from zero, signed and saturated
    function automatic logic [CW-1:0] move_amt(longint pen, longint d, longint den, bit neg);
        longint q, v;
        q = (pen * ((d < 0) ? -d : d) + den / 2) / den;
        v = (q > SMAX) ? SMAX + 1 : q;
        if ((d < 0) != neg) v = -v;
        if (v > SMAX) v = SMAX;
        if (v < SMIN) v = SMIN;
        return v[CW-1:0];
    endfunction

    function automatic t_res resolve_pair(t_pair p);
        longint dx, dy, ax, ay, r2, rsq, xs, ys, dsq, s, pen;
        longint unsigned n, root, b;
        bit   hit;
        t_res res;
        res = '{hit: 1'b0, cdx: '0, cdy: '0, bdx: '0, bdy: '0};
        r2  = 2 * longint'(p.r);
        dx  = axis_off(longint'(p.cx), longint'(p.bx), longint'(p.w));
        dy  = axis_off(longint'(p.cy), longint'(p.by), longint'(p.h));
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        rsq = r2 * r2;
        hit = 1'b0;
        dsq = 0;
        if (ax <= r2 && ay <= r2) begin
            xs = ax * ax;
            ys = ay * ay;
            if (xs <= rsq) begin
                hit = (p.cmd == CMD_DETECT) ? (ys < rsq - xs) : (ys <= rsq - xs);
                dsq = xs + ys;
            end
        end
        if (!hit) return res;
        res.hit = 1'b1;
        if (p.cmd == CMD_DETECT || dsq == 0) return res;
        // bit-at-a-time integer square root
        n    = dsq;
        root = 0;
        b    = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n    = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        s   = longint'(root);
        pen = (r2 >= s) ? r2 - s : 0;
        case (p.cmd)
            CMD_STOP_CIRCLE: begin
                res.cdx = move_amt(pen, dx, 2 * s, 1'b0);
                res.cdy = move_amt(pen, dy, 2 * s, 1'b0);
            end
            CMD_STOP_BOX: begin
                res.bdx = move_amt(pen, dx, 2 * s, 1'b1);
                res.bdy = move_amt(pen, dy, 2 * s, 1'b1);
            end
            default: begin
                res.cdx = move_amt(pen, dx, 4 * s, 1'b0);
                res.cdy = move_amt(pen, dy, 4 * s, 1'b0);
                res.bdx = move_amt(pen, dx, 4 * s, 1'b1);
                res.bdy = move_amt(pen, dy, 4 * s, 1'b1);
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones; calm stretches
    function automatic int gap_len();
        int u;
        if ((n_sent / 150) % 3 == 1) return 0;
        u = $urandom_range(99);
        if (u < 60) return 0;
        if (u < 90) return $urandom_range(3, 1);
        if (u < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic t_pair mk(t_cmd cmd, longint cx, longint cy, longint r,
                                 longint bx, longint by, longint w, longint h);
        t_pair p;
        p.cmd = cmd;
        p.cx  = cx[CW-1:0];
        p.cy  = cy[CW-1:0];
        p.r   = r[CW-2:0];
        p.bx  = bx[CW-1:0];
        p.by  = by[CW-1:0];
        p.w   = w[CW-2:0];
        p.h   = h[CW-2:0];
        return p;
    endfunction

    // random pair: mostly a circle placed around a small box so contact is
    // common, the rest with every field drawn over its full range
    function automatic t_pair rand_pair();
        t_pair  p;
        longint bx, by, w, h, r, span;
        if ($urandom_range(99) < 25) begin
            p.cmd = t_cmd'($urandom_range(3));
            p.cx  = CW'($urandom);
            p.cy  = CW'($urandom);
            p.r   = (CW-1)'($urandom);
            p.bx  = CW'($urandom);
            p.by  = CW'($urandom);
            p.w   = (CW-1)'($urandom);
            p.h   = (CW-1)'($urandom);
            return p;
        end
        bx   = longint'($urandom_range(2097152)) - 1048576;
        by   = longint'($urandom_range(2097152)) - 1048576;
        w    = longint'($urandom_range(($urandom_range(9) == 0) ? 8388607 : 4096));
        h    = longint'($urandom_range(($urandom_range(9) == 0) ? 8388607 : 4096));
        r    = longint'($urandom_range(($urandom_range(9) == 0) ? 8388607 : 4096));
        span = w / 2 + h / 2 + r + 16;
        if (span > 4000000) span = 4000000;
        return mk(t_cmd'($urandom_range(3)),
                  bx + longint'($urandom_range(2 * span)) - span,
                  by + longint'($urandom_range(2 * span)) - span,
                  r, bx, by, w, h);
    endfunction

    // drive one beat from a falling edge, hold until taken, then a random gap
    task automatic send_beat(t_pair p, t_res exp_res);
        int g;
        i_valid         = 1'b1;
        i_cmd           = p.cmd;
        i_circle_x      = p.cx;
        i_circle_y      = p.cy;
        i_circle_radius = p.r;
        i_box_x         = p.bx;
        i_box_y         = p.by;
        i_box_width     = p.w;
        i_box_height    = p.h;
        do @(posedge i_clk); while (!o_ready);
        pending_res.push_back(exp_res);
        n_sent++;
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // result checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_res.size() == 0) begin
                $display("unexpected result beat %0d", n_results);
                n_errors++;
            end else begin
                want = pending_res.pop_front();
                if (o_hit !== want.hit)       report("hit", o_hit, want.hit);
                if (o_circle_dx !== want.cdx) report("circle_dx", o_circle_dx, want.cdx);
                if (o_circle_dy !== want.cdy) report("circle_dy", o_circle_dy, want.cdy);
                if (o_box_dx !== want.bdx)    report("box_dx", o_box_dx, want.bdx);
                if (o_box_dy !== want.bdy)    report("box_dy", o_box_dy, want.bdy);
                if (want.hit) n_hits++;
                if (want.cdx != 0 || want.cdy != 0 || want.bdx != 0 || want.bdy != 0)
                    n_moves++;
            end
            n_results++;
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_MAX) begin
            $display("timeout after %0d idle cycles", idle_count);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, one long hold-off to back the pipe up
    // ------------------------------------------------------------------------
    initial begin
        int g;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held_off && n_sent >= 300) begin
                // long hold-off while the sender keeps offering beats
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                i_ready <= 1'b1;
                @(negedge i_clk);
            end else begin
                g = gap_len();
                if (g > 0) begin
                    i_ready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                i_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_row  rows[$];
        t_res  zero;
        t_res  touch;
        t_pair p;
        zero  = '{hit: 1'b0, cdx: '0, cdy: '0, bdx: '0, bdy: '0};
        touch = '{hit: 1'b1, cdx: '0, cdy: '0, bdx: '0, bdy: '0};

        // zero radius in detect mode never hits, even at the box center
        rows.push_back('{mk(CMD_DETECT, 0, 0, 0, 0, 0, 100, 100), 1'b1, zero});
        // center inside the box: hit without moves in every mode
        rows.push_back('{mk(CMD_DETECT, 5, -5, 1, 0, 0, 100, 100), 1'b1, touch});
        rows.push_back('{mk(CMD_STOP_CIRCLE, 5, -5, 9, 0, 0, 100, 100), 1'b1, touch});
        rows.push_back('{mk(CMD_STOP_BOX, -20, 30, 9, 0, 0, 100, 100), 1'b1, touch});
        rows.push_back('{mk(CMD_PUSH, 50, 50, 0, 0, 0, 100, 100), 1'b1, touch});
        // far apart at opposite coordinate extremes
        rows.push_back('{mk(CMD_DETECT, -8388608, -8388608, 5, 8388607, 8388607, 0, 0),
                         1'b1, zero});
        rows.push_back('{mk(CMD_PUSH, -8388608, 8388607, 5, 8388607, -8388608, 0, 0),
                         1'b1, zero});
        // exact touch of a point box: strict compare misses, others hit, no pen
        rows.push_back('{mk(CMD_DETECT, 10, 0, 10, 0, 0, 0, 0), 1'b1, zero});
        rows.push_back('{mk(CMD_STOP_CIRCLE, 10, 0, 10, 0, 0, 0, 0), 1'b1, touch});
        rows.push_back('{mk(CMD_PUSH, 0, -10, 10, 0, 0, 0, 0), 1'b1, touch});
        // partial overlaps on left and right sides and on corners, in every mode
        rows.push_back('{mk(CMD_STOP_CIRCLE, 130, 20, 60, 0, 0, 200, 100), 1'b0, zero});
        rows.push_back('{mk(CMD_STOP_BOX, -130, 20, 60, 0, 0, 200, 100), 1'b0, zero});
        rows.push_back('{mk(CMD_PUSH, 110, -75, 40, 0, 0, 200, 100), 1'b0, zero});
        rows.push_back('{mk(CMD_DETECT, -110, 75, 40, 0, 0, 200, 100), 1'b0, zero});
        rows.push_back('{mk(CMD_PUSH, -3, 7, 5, 1, 1, 0, 0), 1'b0, zero});
        // largest radius and sizes, near saturation of the moves
        rows.push_back('{mk(CMD_STOP_CIRCLE, 1, 0, 8388607, 0, 0, 0, 0), 1'b0, zero});
        rows.push_back('{mk(CMD_STOP_BOX, -1, -1, 8388607, 0, 0, 0, 0), 1'b0, zero});
        rows.push_back('{mk(CMD_PUSH, 8388607, 8388607, 8388607, -8388608, -8388608,
                            8388607, 8388607), 1'b0, zero});
        rows.push_back('{mk(CMD_STOP_CIRCLE, -8388608, 8388607, 8388607, 8388607,
                            -8388608, 8388607, 0), 1'b0, zero});
        rows.push_back('{mk(CMD_DETECT, 8388607, -8388608, 8388607, 0, 0, 8388607,
                            8388607), 1'b0, zero});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k])
            send_beat(rows[k].pair, rows[k].typed ? rows[k].res : resolve_pair(rows[k].pair));
        repeat (N_RANDOM) begin
            p = rand_pair();
            send_beat(p, resolve_pair(p));
        end
        i_valid = 1'b0;

        // drain, then let the pipe run empty for a while
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("sent %0d pairs over all four modes, %0d results checked", n_sent, n_results);
        $display("%0d hits, %0d with nonzero moves, one long receiver hold-off", n_hits, n_moves);
        if (n_errors == 0 && pending_res.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
